@@ rtl/pcd_pkg.sv @@
package pcd_pkg;

  localparam int unsigned ORDER         = 4;
  localparam int unsigned BITS_PER_WORD = 16;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned FRAME_W       = 16;
  localparam int unsigned BIT_CNT_W     = $clog2(BITS_PER_WORD);
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [BITS_PER_WORD-1:0] word_t;
  typedef logic [SAMPLE_W-1:0]      sample_t;
  typedef logic [FRAME_W-1:0]       frame_len_t;

  localparam frame_len_t FRAME_LEN_RESET = frame_len_t'(512);
  localparam sample_t    STEP_UP         = sample_t'(1);
  localparam sample_t    STEP_DOWN       = '1;

endpackage

@@ rtl/pcd_queue.sv @@
module pcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pcd_pkg::word_t in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pcd_pkg::word_t out_word_o
);

  pcd_pkg::word_t                       mem_q [pcd_pkg::QUEUE_DEPTH];
  logic [pcd_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [pcd_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [pcd_pkg::QUEUE_CNT_W-1:0]      count_q, count_d;
  logic                                 push, pop;

  assign in_ready_o  = (count_q != pcd_pkg::QUEUE_CNT_W'(pcd_pkg::QUEUE_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_word_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == pcd_pkg::QUEUE_PTR_W'(pcd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == pcd_pkg::QUEUE_PTR_W'(pcd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word_i;
    end
  end

endmodule

@@ rtl/pcd_integ.sv @@
module pcd_integ (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             word_valid_i,
  output logic             word_ready_o,
  input  pcd_pkg::word_t   word_i,
  output logic             integ_valid_o,
  input  logic             integ_ready_i,
  output pcd_pkg::sample_t integ_o
);

  pcd_pkg::sample_t              integ_q [pcd_pkg::ORDER];
  pcd_pkg::sample_t              integ_d [pcd_pkg::ORDER];
  pcd_pkg::word_t                shift_q, shift_d;
  logic [pcd_pkg::BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          pend_valid_q, pend_valid_d;
  pcd_pkg::sample_t              pend_q, pend_d;
  logic                          last_bit, step, load;
  pcd_pkg::sample_t              bit_step;

  assign last_bit = (cnt_q == pcd_pkg::BIT_CNT_W'(pcd_pkg::BITS_PER_WORD - 1));
  // The last bit may only go once the finished value has somewhere to go.
  assign step     = busy_q && !(last_bit && pend_valid_q && !integ_ready_i);
  assign load     = !busy_q || (step && last_bit);
  assign word_ready_o  = load;
  assign integ_valid_o = pend_valid_q;
  assign integ_o       = pend_q;
  assign bit_step      = shift_q[pcd_pkg::BITS_PER_WORD-1] ? pcd_pkg::STEP_UP
                                                           : pcd_pkg::STEP_DOWN;

  always_comb begin
    integ_d[0] = integ_q[0] + bit_step;
    for (int unsigned s = 1; s < pcd_pkg::ORDER; s++) begin
      integ_d[s] = integ_q[s] + integ_d[s-1];
    end
  end

  always_comb begin
    shift_d      = shift_q;
    cnt_d        = cnt_q;
    busy_d       = busy_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (pend_valid_q && integ_ready_i) begin
      pend_valid_d = 1'b0;
    end
    if (step) begin
      shift_d = {shift_q[pcd_pkg::BITS_PER_WORD-2:0], 1'b0};
      cnt_d   = cnt_q + 1'b1;
      if (last_bit) begin
        pend_d       = integ_d[pcd_pkg::ORDER-1];
        pend_valid_d = 1'b1;
        busy_d       = 1'b0;
      end
    end
    if (load && word_valid_i) begin
      shift_d = word_i;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned s = 0; s < pcd_pkg::ORDER; s++) begin
        integ_q[s] <= '0;
      end
      cnt_q        <= '0;
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (step) begin
        for (int unsigned s = 0; s < pcd_pkg::ORDER; s++) begin
          integ_q[s] <= integ_d[s];
        end
      end
      cnt_q        <= cnt_d;
      busy_q       <= busy_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    pend_q  <= pend_d;
  end

endmodule

@@ rtl/pcd_comb.sv @@
module pcd_comb (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcd_pkg::frame_len_t  frame_len_i,
  input  logic                 integ_valid_i,
  output logic                 integ_ready_o,
  input  pcd_pkg::sample_t     integ_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pcd_pkg::sample_t     out_sample_o,
  output logic                 out_last_o
);

  pcd_pkg::sample_t      delay_q [pcd_pkg::ORDER];
  pcd_pkg::sample_t      stage   [pcd_pkg::ORDER+1];
  pcd_pkg::frame_len_t   count_q, count_d;
  logic [pcd_pkg::FRAME_W:0] count_next;
  logic                  frame_done;
  logic                  fire;
  logic                  out_valid_q, out_valid_d;
  pcd_pkg::sample_t      out_sample_q;
  logic                  out_last_q;

  assign integ_ready_o = !out_valid_q || out_ready_i;
  assign fire          = integ_valid_i && integ_ready_o;
  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign out_last_o    = out_last_q;

  always_comb begin
    stage[0] = integ_i;
    for (int unsigned s = 0; s < pcd_pkg::ORDER; s++) begin
      stage[s+1] = stage[s] - delay_q[s];
    end
  end

  // A frame length of zero, or one lowered below the count, closes the frame at once.
  assign count_next = {1'b0, count_q} + 1'b1;
  assign frame_done = (count_next >= {1'b0, frame_len_i});

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
      count_d     = frame_done ? '0 : count_next[pcd_pkg::FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned s = 0; s < pcd_pkg::ORDER; s++) begin
        delay_q[s] <= '0;
      end
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        for (int unsigned s = 0; s < pcd_pkg::ORDER; s++) begin
          delay_q[s] <= stage[s];
        end
      end
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_sample_q <= stage[pcd_pkg::ORDER];
      out_last_q   <= frame_done;
    end
  end

endmodule

@@ rtl/pdm_cic_decimator.sv @@
// Fourth-order CIC decimator for PDM microphones: each input item is a 16-bit word of PDM
// bits, most significant bit oldest, and each produces one signed 16-bit PCM sample on the
// output stream, with tlast raised on the sample that completes a frame of frame_length
// samples (zero means every sample closes a frame). All arithmetic wraps modulo 2^16.
// The integrator cascade is bit-serial, one PDM bit per clock while a word is in hand, save
// that the last bit waits while the previous sum is still held; a two-entry input queue
// takes the next word while the current one is integrated, and the output register holds
// a finished sample while the integrators go on. frame_length is written on the cfg
// channel, which is always ready, and should only change while the block is idle.
module pdm_cic_decimator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  pcd_pkg::frame_len_t     cfg_data_i,     // frame_length
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [15:0]             s_axis_tdata_i, // pdm_word
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [15:0]             m_axis_tdata_o, // pcm_sample
  output logic                    m_axis_tlast_o  // frame_last
);

  pcd_pkg::frame_len_t frame_len_q;
  logic                q_valid, q_ready;
  pcd_pkg::word_t      q_word;
  logic                integ_valid, integ_ready;
  pcd_pkg::sample_t    integ_value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= pcd_pkg::FRAME_LEN_RESET;
    end else if (cfg_valid_i) begin
      frame_len_q <= cfg_data_i;
    end
  end

  pcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_word_i   (s_axis_tdata_i),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_word_o  (q_word)
  );

  pcd_integ u_integ (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_valid_i  (q_valid),
    .word_ready_o  (q_ready),
    .word_i        (q_word),
    .integ_valid_o (integ_valid),
    .integ_ready_i (integ_ready),
    .integ_o       (integ_value)
  );

  pcd_comb u_comb (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_len_i   (frame_len_q),
    .integ_valid_i (integ_valid),
    .integ_ready_o (integ_ready),
    .integ_i       (integ_value),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_sample_o  (m_axis_tdata_o),
    .out_last_o    (m_axis_tlast_o)
  );

endmodule
